[rtl/secp256k1_modular_inverse_unit_assert.svh]
// Assertion macros shared by the modular inverse unit.
// Setting ASSERT_OFF leaves every use empty.
`ifndef SECP256K1_MODULAR_INVERSE_UNIT_ASSERT_SVH
`define SECP256K1_MODULAR_INVERSE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define SMI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define SMI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SMI_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/secp_inv_pkg.sv]
package secp_inv_pkg;

  localparam int unsigned LimbW = 64;
  localparam int unsigned Limbs = 4;
  localparam int unsigned WordW = LimbW * Limbs;

  typedef logic [WordW-1:0] word_t;

  // p = 2^256 - 2^32 - 977
  localparam word_t PRIME_P = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                               64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2F};

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic  cout;
    word_t sum;
  } alu_res_t;

endpackage

[rtl/secp_inv_alu.sv]
// Shared 256-bit adder. For a subtraction the carry out is high when no
// borrow occurred.
module secp_inv_alu (
  input  secp_inv_pkg::word_t    a_i,
  input  secp_inv_pkg::word_t    b_i,
  input  secp_inv_pkg::alu_op_e  op_i,
  output secp_inv_pkg::alu_res_t res_o
);
  import secp_inv_pkg::*;

  word_t b_eff;
  logic  cin;

  always_comb begin
    cin   = (op_i == ALU_SUB);
    b_eff = cin ? ~b_i : b_i;
    res_o = alu_res_t'({1'b0, a_i} + {1'b0, b_eff} + {{WordW{1'b0}}, cin});
  end

endmodule

[rtl/secp256k1_modular_inverse_unit.sv]
// Channel   Dir  Beat contents
// s_axis    in   tdata[255:0] = value_limb0..value_limb3
// m_axis    out  tdata[255:0] = inverse_limb0..inverse_limb3
//
// Every step goes through the single shared 256-bit adder, one step per cycle.
// A subtract round computes u - v in S_LOOP and x1 - x2 in S_CX1 when u is
// not below v, or v - u in S_SUBV and x2 - x1 in S_CX2 when v is larger; a
// borrow on the coefficient adds p back in S_FIX1 or S_FIX2. A value costs
// up to about 512 halvings and as many rounds. A zero value or p itself ends
// the loop early and returns 0. The beat is loaded on its accept edge; after
// the last step S_LOOP sees the zero and S_FIN hands the result off.
// Reset clears the sequencer and the output valid flag. A new value is
// accepted as soon as the previous result sits in the output register, and
// a stalled result holds the block in its final state.
`include "secp256k1_modular_inverse_unit_assert.svh"

module secp256k1_modular_inverse_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,   // value_limb0, value_limb1, value_limb2, value_limb3
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata    // inverse_limb0, inverse_limb1, inverse_limb2,
                                       // inverse_limb3
);
  import secp_inv_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOP = 3'd1;
  localparam logic [2:0] S_SUBV = 3'd2;
  localparam logic [2:0] S_CX1  = 3'd3;
  localparam logic [2:0] S_CX2  = 3'd4;
  localparam logic [2:0] S_FIX1 = 3'd5;
  localparam logic [2:0] S_FIX2 = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;
  word_t      u_q, u_d, v_q, v_d, x1_q, x1_d, x2_q, x2_d;
  word_t      out_q, out_d;
  logic       out_valid_q, out_valid_d;

  word_t      alu_a, alu_b;
  alu_op_e    alu_op;
  alu_res_t   alu_res;

  logic       u_zero, v_zero, in_acc, out_free;

  secp_inv_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .op_i (alu_op),
    .res_o(alu_res)
  );

  assign u_zero        = (u_q == '0);
  assign v_zero        = (v_q == '0);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Operand selection depends on registers only.
  always_comb begin
    alu_a  = x1_q;
    alu_b  = '0;
    alu_op = ALU_ADD;

    unique case (state_q)
      S_LOOP: begin
        if (!u_q[0]) begin
          alu_a = x1_q;
          alu_b = x1_q[0] ? PRIME_P : '0;
        end else if (!v_q[0]) begin
          alu_a = x2_q;
          alu_b = x2_q[0] ? PRIME_P : '0;
        end else begin
          alu_a  = u_q;
          alu_b  = v_q;
          alu_op = ALU_SUB;
        end
      end
      S_SUBV: begin
        alu_a  = v_q;
        alu_b  = u_q;
        alu_op = ALU_SUB;
      end
      S_CX1: begin
        alu_a  = x1_q;
        alu_b  = x2_q;
        alu_op = ALU_SUB;
      end
      S_CX2: begin
        alu_a  = x2_q;
        alu_b  = x1_q;
        alu_op = ALU_SUB;
      end
      S_FIX1: begin
        alu_a = x1_q;
        alu_b = PRIME_P;
      end
      S_FIX2: begin
        alu_a = x2_q;
        alu_b = PRIME_P;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    u_d         = u_q;
    v_d         = v_q;
    x1_d        = x1_q;
    x2_d        = x2_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      S_IDLE: begin
        // A zero value falls straight through the loop and returns x2 = 0.
        if (in_acc) begin
          u_d     = s_axis_tdata;
          v_d     = PRIME_P;
          x1_d    = word_t'(1);
          x2_d    = '0;
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (u_zero || v_zero) begin
          state_d = S_FIN;
        end else if (!u_q[0]) begin
          // Halve x1 modulo p: add p when odd, keep the carry as the new top bit.
          u_d   = u_q >> 1;
          x1_d  = {alu_res.cout, alu_res.sum[WordW-1:1]};
        end else if (!v_q[0]) begin
          v_d   = v_q >> 1;
          x2_d  = {alu_res.cout, alu_res.sum[WordW-1:1]};
        end else begin
          // The borrow of u - v doubles as the compare.
          if (alu_res.cout) begin
            u_d     = alu_res.sum;
            state_d = S_CX1;
          end else begin
            state_d = S_SUBV;
          end
        end
      end
      S_SUBV: begin
        v_d     = alu_res.sum;
        state_d = S_CX2;
      end
      S_CX1: begin
        x1_d    = alu_res.sum;
        state_d = alu_res.cout ? S_LOOP : S_FIX1;
      end
      S_CX2: begin
        x2_d    = alu_res.sum;
        state_d = alu_res.cout ? S_LOOP : S_FIX2;
      end
      S_FIX1: begin
        x1_d    = alu_res.sum;
        state_d = S_LOOP;
      end
      S_FIX2: begin
        x2_d    = alu_res.sum;
        state_d = S_LOOP;
      end
      S_FIN: begin
        if (out_free) begin
          out_d       = v_zero ? x1_q : x2_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    x1_q  <= x1_d;
    x2_q  <= x2_d;
    out_q <= out_d;
  end

  `SMI_ASSERT(a_coef_range, clk_i, rst_ni,
              ((state_q == S_LOOP || state_q == S_FIN) |-> (x1_q < PRIME_P && x2_q < PRIME_P)),
              "coefficient left the range below p")
  `SMI_ASSERT(a_subv_order, clk_i, rst_ni,
              ((state_q == S_SUBV) |-> (u_q[0] && v_q[0] && u_q < v_q)),
              "v - u taken with u not below v or an even operand")
  `SMI_ASSERT(a_load, clk_i, rst_ni,
              ((s_axis_tvalid && s_axis_tready) |=>
               (state_q == S_LOOP && v_q == PRIME_P && x2_q == '0)),
              "loop not started from p after accept")
  `SMI_ASSERT(a_fin_wait, clk_i, rst_ni,
              ((state_q == S_FIN && m_axis_tvalid && !m_axis_tready) |=> (state_q == S_FIN)),
              "result dropped over a stalled beat")

endmodule
